// ----- rtl/tlpm_pkg.sv -----
// Shared types and constants for the tiled-to-linear pixel mapper.
// Used by the interfaces, the register block, the controller, the datapath and the top level.
// Has no dependencies.
package tlpm_pkg;

	localparam int unsigned MAX_TILES_WIDE    = 256;
	localparam int unsigned MAX_TILE_ROWS     = 256;
	localparam int unsigned MAX_METATILE_SIDE = 16;

	localparam int unsigned ROWS_PER_TILE = 8;
	localparam int unsigned MAX_MWIDE     = 256;
	localparam int unsigned MAX_COUNT     = 65536;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned OFFSET_W = 22;
	localparam int unsigned REG_IDX_W  = 3;
	localparam int unsigned REG_DATA_W = 17;

	typedef logic [1:0] depth_t;
	localparam depth_t DEPTH_1BPP = 2'd0;
	localparam depth_t DEPTH_4BPP = 2'd1;
	localparam depth_t DEPTH_8BPP = 2'd2;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_DEPTH_MODE      = 3'd0;
	localparam reg_idx_t REG_METATILES_WIDE  = 3'd1;
	localparam reg_idx_t REG_METATILE_WIDTH  = 3'd2;
	localparam reg_idx_t REG_METATILE_HEIGHT = 3'd3;
	localparam reg_idx_t REG_INVERT          = 3'd4;
	localparam reg_idx_t REG_TILE_COUNT      = 3'd5;

	typedef struct packed {
		depth_t      depth;
		logic        invert;
		logic [4:0]  mw;
		logic [4:0]  mh;
		logic [8:0]  mwide;
		logic [16:0] count;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic calc;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_FINISH
	} ctrl_state_t;

endpackage

// ----- rtl/tlpm_if.sv -----
// Handshake channels of the pixel mapper: input bytes, results and register writes.
// Depends on tlpm_pkg for the payload widths.
interface tlpm_in_if;
	logic                           valid;
	logic                           ready;
	logic [tlpm_pkg::BYTE_W-1:0]    tile_byte;

	modport source (output valid, output tile_byte, input ready);
	modport sink (input valid, input tile_byte, output ready);
endinterface

interface tlpm_out_if;
	logic                           valid;
	logic                           ready;
	logic [tlpm_pkg::OFFSET_W-1:0]  linear_offset;
	logic [tlpm_pkg::BYTE_W-1:0]    pixel_byte;
	logic                           image_done;
	logic                           out_of_range;

	modport source (output valid, output linear_offset, output pixel_byte,
		output image_done, output out_of_range, input ready);
	modport sink (input valid, input linear_offset, input pixel_byte,
		input image_done, input out_of_range, output ready);
endinterface

interface tlpm_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [tlpm_pkg::REG_IDX_W-1:0]  index;
	logic [tlpm_pkg::REG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/tlpm_cfg_regs.sv -----
// Configuration registers of the pixel mapper and the clamping of their values.
// Depends on tlpm_pkg.
module tlpm_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_valid,
	output logic                            wr_ready,
	input  logic [tlpm_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [tlpm_pkg::REG_DATA_W-1:0] wr_data,
	output tlpm_pkg::cfg_t                  cfg
);

	function automatic int unsigned max1(input int unsigned v);
		return (v < 1) ? 1 : v;
	endfunction

	// Widest metatile row that fits, indexed by the clamped metatile width.
	localparam logic [10:0] WMAX_TABLE [32] = '{
		11'(max1(tlpm_pkg::MAX_TILES_WIDE / 1)),  11'(max1(tlpm_pkg::MAX_TILES_WIDE / 1)),
		11'(max1(tlpm_pkg::MAX_TILES_WIDE / 2)),  11'(max1(tlpm_pkg::MAX_TILES_WIDE / 3)),
		11'(max1(tlpm_pkg::MAX_TILES_WIDE / 4)),  11'(max1(tlpm_pkg::MAX_TILES_WIDE / 5)),
		11'(max1(tlpm_pkg::MAX_TILES_WIDE / 6)),  11'(max1(tlpm_pkg::MAX_TILES_WIDE / 7)),
		11'(max1(tlpm_pkg::MAX_TILES_WIDE / 8)),  11'(max1(tlpm_pkg::MAX_TILES_WIDE / 9)),
		11'(max1(tlpm_pkg::MAX_TILES_WIDE / 10)), 11'(max1(tlpm_pkg::MAX_TILES_WIDE / 11)),
		11'(max1(tlpm_pkg::MAX_TILES_WIDE / 12)), 11'(max1(tlpm_pkg::MAX_TILES_WIDE / 13)),
		11'(max1(tlpm_pkg::MAX_TILES_WIDE / 14)), 11'(max1(tlpm_pkg::MAX_TILES_WIDE / 15)),
		11'(max1(tlpm_pkg::MAX_TILES_WIDE / 16)), 11'(max1(tlpm_pkg::MAX_TILES_WIDE / 17)),
		11'(max1(tlpm_pkg::MAX_TILES_WIDE / 18)), 11'(max1(tlpm_pkg::MAX_TILES_WIDE / 19)),
		11'(max1(tlpm_pkg::MAX_TILES_WIDE / 20)), 11'(max1(tlpm_pkg::MAX_TILES_WIDE / 21)),
		11'(max1(tlpm_pkg::MAX_TILES_WIDE / 22)), 11'(max1(tlpm_pkg::MAX_TILES_WIDE / 23)),
		11'(max1(tlpm_pkg::MAX_TILES_WIDE / 24)), 11'(max1(tlpm_pkg::MAX_TILES_WIDE / 25)),
		11'(max1(tlpm_pkg::MAX_TILES_WIDE / 26)), 11'(max1(tlpm_pkg::MAX_TILES_WIDE / 27)),
		11'(max1(tlpm_pkg::MAX_TILES_WIDE / 28)), 11'(max1(tlpm_pkg::MAX_TILES_WIDE / 29)),
		11'(max1(tlpm_pkg::MAX_TILES_WIDE / 30)), 11'(max1(tlpm_pkg::MAX_TILES_WIDE / 31))
	};

	logic [1:0]  depth_q;
	logic [8:0]  mwide_q;
	logic [4:0]  mw_q;
	logic [4:0]  mh_q;
	logic        invert_q;
	logic [16:0] count_q;

	logic [4:0]  mw_c;
	logic [4:0]  mh_c;
	logic [10:0] mwide_c;
	logic [10:0] wmax_c;
	logic        wr_fire;

	assign wr_ready = 1'b1;
	assign wr_fire  = wr_valid && wr_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= tlpm_pkg::DEPTH_4BPP;
			mwide_q  <= 9'd1;
			mw_q     <= 5'd1;
			mh_q     <= 5'd1;
			invert_q <= 1'b0;
			count_q  <= 17'd1;
		end else if (wr_fire) begin
			case (wr_index)
				tlpm_pkg::REG_DEPTH_MODE:      depth_q  <= wr_data[1:0];
				tlpm_pkg::REG_METATILES_WIDE:  mwide_q  <= wr_data[8:0];
				tlpm_pkg::REG_METATILE_WIDTH:  mw_q     <= wr_data[4:0];
				tlpm_pkg::REG_METATILE_HEIGHT: mh_q     <= wr_data[4:0];
				tlpm_pkg::REG_INVERT:          invert_q <= wr_data[0];
				tlpm_pkg::REG_TILE_COUNT:      count_q  <= wr_data[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (mw_q == 5'd0) begin
			mw_c = 5'd1;
		end else if (32'(mw_q) > tlpm_pkg::MAX_METATILE_SIDE) begin
			mw_c = 5'(tlpm_pkg::MAX_METATILE_SIDE);
		end else begin
			mw_c = mw_q;
		end

		if (mh_q == 5'd0) begin
			mh_c = 5'd1;
		end else if (32'(mh_q) > tlpm_pkg::MAX_METATILE_SIDE) begin
			mh_c = 5'(tlpm_pkg::MAX_METATILE_SIDE);
		end else begin
			mh_c = mh_q;
		end

		if (mwide_q == 9'd0) begin
			mwide_c = 11'd1;
		end else if (32'(mwide_q) > tlpm_pkg::MAX_MWIDE) begin
			mwide_c = 11'(tlpm_pkg::MAX_MWIDE);
		end else begin
			mwide_c = 11'(mwide_q);
		end

		wmax_c = WMAX_TABLE[mw_c];

		cfg.depth  = depth_q;
		cfg.invert = invert_q;
		cfg.mw     = mw_c;
		cfg.mh     = mh_c;
		cfg.mwide  = (mwide_c > wmax_c) ? wmax_c[8:0] : mwide_c[8:0];

		if (count_q == 17'd0) begin
			cfg.count = 17'd1;
		end else if (32'(count_q) > tlpm_pkg::MAX_COUNT) begin
			cfg.count = 17'(tlpm_pkg::MAX_COUNT);
		end else begin
			cfg.count = count_q;
		end
	end

endmodule

// ----- rtl/tlpm_ctrl.sv -----
// Controller of the pixel mapper: sequences accept, address calculation and result load.
// Depends on tlpm_pkg.
module tlpm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tlpm_pkg::status_t status,
	output tlpm_pkg::cmd_t    cmd
);

	tlpm_pkg::ctrl_state_t state_q;
	tlpm_pkg::ctrl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlpm_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			tlpm_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = tlpm_pkg::ST_CALC;
				end
			end
			tlpm_pkg::ST_CALC: begin
				state_nxt = tlpm_pkg::ST_FINISH;
			end
			tlpm_pkg::ST_FINISH: begin
				if (status.out_free) begin
					state_nxt = tlpm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = tlpm_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.accept = 1'b0;
		cmd.calc   = 1'b0;
		cmd.load   = 1'b0;
		case (state_q)
			tlpm_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			tlpm_pkg::ST_CALC: begin
				cmd.calc = 1'b1;
			end
			tlpm_pkg::ST_FINISH: begin
				cmd.load = status.out_free;
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_accept_to_calc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == tlpm_pkg::ST_CALC)
		else $error("Accepted beat did not move the controller to the calculation step.");
	a_calc_to_finish: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tlpm_pkg::ST_CALC |=> state_q == tlpm_pkg::ST_FINISH)
		else $error("Calculation step did not advance to the finish step.");
	a_finish_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tlpm_pkg::ST_FINISH && !status.out_free) |=>
		state_q == tlpm_pkg::ST_FINISH)
		else $error("Result left the finish step while the output register was full.");
`endif

endmodule

// ----- rtl/tlpm_datapath.sv -----
// Datapath of the pixel mapper: position counters, pixel conversion, offset arithmetic
// and the output register. Depends on tlpm_pkg.
module tlpm_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tlpm_pkg::cfg_t                 cfg,
	input  tlpm_pkg::cmd_t                 cmd,
	output tlpm_pkg::status_t              status,
	input  logic [tlpm_pkg::BYTE_W-1:0]    tile_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tlpm_pkg::OFFSET_W-1:0]  linear_offset,
	output logic [tlpm_pkg::BYTE_W-1:0]    pixel_byte,
	output logic                           image_done,
	output logic                           out_of_range
);

	logic [2:0]  byte_in_row_q;
	logic [2:0]  row_in_tile_q;
	logic [3:0]  subtile_col_q;
	logic [3:0]  subtile_row_q;
	logic [7:0]  metatile_col_q;
	logic [15:0] metatile_row_q;
	logic [16:0] tiles_done_q;

	logic [1:0]  shift_c;
	logic [3:0]  bpr_c;
	logic [7:0]  pix_c;
	logic [7:0]  inv_mask_c;
	logic [3:0]  byte_nxt_c;
	logic [3:0]  row_nxt_c;
	logic [17:0] tiles_nxt_c;
	logic [4:0]  sc_nxt_c;
	logic [4:0]  sr_nxt_c;
	logic [8:0]  mc_nxt_c;
	logic        byte_wrap_c;
	logic        row_wrap_c;
	logic        done_c;

	logic [2:0]  byte_in_row_s1;
	logic [2:0]  row_in_tile_s1;
	logic [3:0]  subtile_col_s1;
	logic [3:0]  subtile_row_s1;
	logic [7:0]  metatile_col_s1;
	logic [15:0] metatile_row_s1;
	logic [7:0]  pix_s1;
	logic        done_s1;

	logic [20:0] tile_row_s2;
	logic [12:0] tile_col_s2;
	logic [16:0] pitch_s2;

	logic [21:0] rowline_c;
	logic [21:0] offset_c;
	logic        oor_c;

	logic        out_valid_q;
	logic [21:0] offset_q;
	logic [7:0]  pix_q;
	logic        done_q;
	logic        oor_q;

	always_comb begin
		inv_mask_c = {8{cfg.invert}};
		case (cfg.depth)
			tlpm_pkg::DEPTH_1BPP: begin
				shift_c = 2'd0;
				pix_c   = {tile_byte[0], tile_byte[1], tile_byte[2], tile_byte[3],
					tile_byte[4], tile_byte[5], tile_byte[6], tile_byte[7]} ^ inv_mask_c;
			end
			tlpm_pkg::DEPTH_4BPP: begin
				shift_c = 2'd2;
				pix_c   = {tile_byte[3:0], tile_byte[7:4]} ^ inv_mask_c;
			end
			default: begin
				shift_c = 2'd3;
				pix_c   = tile_byte ^ inv_mask_c;
			end
		endcase
		bpr_c = 4'd1 << shift_c;

		byte_nxt_c  = {1'b0, byte_in_row_q} + 4'd1;
		row_nxt_c   = {1'b0, row_in_tile_q} + 4'd1;
		tiles_nxt_c = {1'b0, tiles_done_q} + 18'd1;
		sc_nxt_c    = {1'b0, subtile_col_q} + 5'd1;
		sr_nxt_c    = {1'b0, subtile_row_q} + 5'd1;
		mc_nxt_c    = {1'b0, metatile_col_q} + 9'd1;

		byte_wrap_c = byte_nxt_c >= bpr_c;
		row_wrap_c  = 32'(row_nxt_c) >= tlpm_pkg::ROWS_PER_TILE;
		done_c      = byte_wrap_c && row_wrap_c && (tiles_nxt_c >= {1'b0, cfg.count});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_in_row_q  <= '0;
			row_in_tile_q  <= '0;
			subtile_col_q  <= '0;
			subtile_row_q  <= '0;
			metatile_col_q <= '0;
			metatile_row_q <= '0;
			tiles_done_q   <= '0;
		end else if (cmd.accept) begin
			if (!byte_wrap_c) begin
				byte_in_row_q <= byte_nxt_c[2:0];
			end else begin
				byte_in_row_q <= '0;
				if (!row_wrap_c) begin
					row_in_tile_q <= row_nxt_c[2:0];
				end else begin
					row_in_tile_q <= '0;
					if (done_c) begin
						tiles_done_q   <= '0;
						subtile_col_q  <= '0;
						subtile_row_q  <= '0;
						metatile_col_q <= '0;
						metatile_row_q <= '0;
					end else begin
						tiles_done_q <= tiles_nxt_c[16:0];
						if (sc_nxt_c < cfg.mw) begin
							subtile_col_q <= sc_nxt_c[3:0];
						end else begin
							subtile_col_q <= '0;
							if (sr_nxt_c < cfg.mh) begin
								subtile_row_q <= sr_nxt_c[3:0];
							end else begin
								subtile_row_q <= '0;
								if (mc_nxt_c < cfg.mwide) begin
									metatile_col_q <= mc_nxt_c[7:0];
								end else begin
									metatile_col_q <= '0;
									metatile_row_q <= metatile_row_q + 16'd1;
								end
							end
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_in_row_s1  <= byte_in_row_q;
			row_in_tile_s1  <= row_in_tile_q;
			subtile_col_s1  <= subtile_col_q;
			subtile_row_s1  <= subtile_row_q;
			metatile_col_s1 <= metatile_col_q;
			metatile_row_s1 <= metatile_row_q;
			pix_s1          <= pix_c;
			done_s1         <= done_c;
		end
		if (cmd.calc) begin
			tile_row_s2 <= 21'(metatile_row_s1) * 21'(cfg.mh) + 21'(subtile_row_s1);
			tile_col_s2 <= 13'(metatile_col_s1) * 13'(cfg.mw) + 13'(subtile_col_s1);
			pitch_s2    <= (17'(cfg.mwide) * 17'(cfg.mw)) << shift_c;
		end
	end

	always_comb begin
		rowline_c = 22'({tile_row_s2, row_in_tile_s1});
		oor_c     = 32'(tile_row_s2) >= tlpm_pkg::MAX_TILE_ROWS;
		offset_c  = 22'(rowline_c * 22'(pitch_s2)) + 22'(16'(tile_col_s2) << shift_c)
			+ 22'(byte_in_row_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			offset_q <= oor_c ? '0 : offset_c;
			pix_q    <= pix_s1;
			done_q   <= done_s1;
			oor_q    <= oor_c;
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign linear_offset   = offset_q;
	assign pixel_byte      = pix_q;
	assign image_done      = done_q;
	assign out_of_range    = oor_q;

`ifndef SYNTHESIS
	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && done_c) |=> (tiles_done_q == '0 && metatile_row_q == '0
		&& metatile_col_q == '0))
		else $error("Position counters did not return to zero after the last tile.");
	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> out_valid_q)
		else $error("Loaded result is not shown as valid.");
	a_taken_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ready && !cmd.load) |=> !out_valid_q)
		else $error("Result stayed valid after its beat was taken.");
`endif

endmodule

// ----- rtl/tiled_to_linear_pixel_mapper_unit.sv -----
// Top level of the tiled-to-linear pixel mapper.
// Depends on tlpm_pkg, the channel interfaces, tlpm_cfg_regs, tlpm_ctrl and tlpm_datapath.

// Each input beat is one byte of 8x8 tile data in tiled order; each output beat gives that
// byte's offset in the linear metatile image and the byte converted to linear pixel order.
// One byte is in work at a time and passes through the accept, a step of small
// multiplications for tile row, tile column and pitch, and a step for the pitch
// multiplication and final add that loads the output register once that register is free.
// The next byte is accepted while a finished result still waits in the output register,
// so a new byte can start before the last result is taken. Register writes are taken at
// any time but must only be made while no byte is in flight.
module tiled_to_linear_pixel_mapper_unit (
	input  logic       clk,
	input  logic       arst_n,
	tlpm_in_if.sink    pix_in,
	tlpm_out_if.source pix_out,
	tlpm_cfg_if.sink   cfg
);

	tlpm_pkg::cfg_t    cfg_vals;
	tlpm_pkg::cmd_t    cmd;
	tlpm_pkg::status_t status;

	tlpm_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg.valid),
		.wr_ready (cfg.ready),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_vals)
	);

	tlpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix_in.valid),
		.in_ready (pix_in.ready),
		.status   (status),
		.cmd      (cmd)
	);

	tlpm_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_vals),
		.cmd           (cmd),
		.status        (status),
		.tile_byte     (pix_in.tile_byte),
		.out_valid     (pix_out.valid),
		.out_ready     (pix_out.ready),
		.linear_offset (pix_out.linear_offset),
		.pixel_byte    (pix_out.pixel_byte),
		.image_done    (pix_out.image_done),
		.out_of_range  (pix_out.out_of_range)
	);

endmodule
